// File: sv/pmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the sample message decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int KIND_W  = 4;
	localparam int VALUE_W = 64;
	localparam int CODE_W  = 2;

	localparam logic [KIND_W-1:0] K_LOCATION    = 4'd0;
	localparam logic [KIND_W-1:0] K_VALUE       = 4'd1;
	localparam logic [KIND_W-1:0] K_LABEL_KEY   = 4'd2;
	localparam logic [KIND_W-1:0] K_EMPTY_LABEL = 4'd6;
	localparam logic [KIND_W-1:0] K_END         = 4'd7;
	localparam logic [KIND_W-1:0] K_ERROR       = 4'd8;

	localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [CODE_W-1:0] ERR_OVERLONG = 2'd1;
	localparam logic [CODE_W-1:0] ERR_TRUNC    = 2'd2;
	localparam logic [CODE_W-1:0] ERR_WIRE     = 2'd3;

	typedef struct packed {
		logic [6:0] payload;
		logic       cont;
		logic       last;
	} byte_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               closes;
		logic               last;
		logic [CODE_W-1:0]  code;
	} out_beat_t;

endpackage
`default_nettype wire

// File: sv/protobuf_sample_message_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_sample_message_decoder_core
// Decodes a protobuf profile sample message one byte per beat into location
// ids, values and label fields, with skipping of unknown fields.
// ----------------------------------------------------------------------------
//  channel   dir   tdata                          tuser                 tlast
//  s_*       in    [7:0] data_byte                -                     end_of_message
//  m_*       out   [63:0] decoded_value,          [3:0] kind,           message_last
//                  [64] closes_label              [5:4] error_code
//
//  one input byte is parsed per cycle, unless a result waits on m_tready
//  a 4-entry byte queue sits between input and parser
//  each input byte passes the byte queue, then the registered result beat
//  bytes that yield no result are consumed without an output beat
//  parser stalls only while a result waits on m_tready
//  reset clears the queue and returns the parser to tag decode
// ----------------------------------------------------------------------------
module protobuf_sample_message_decoder_core import pmd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [63:0] decoded_value, [64] closes_label
	output logic [5:0]       m_tuser,   // [3:0] kind, [5:4] error_code
	output logic             m_tlast
);

	logic        q_valid;
	byte_beat_t  q_beat;
	logic        q_pop;
	out_beat_t   res;

	pmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_beat   (q_beat),
		.q_pop    (q_pop)
	);

	pmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_beat    (q_beat),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_beat  (res),
		.out_ready (m_tready)
	);

	assign m_tdata = {7'd0, res.closes, res.value};
	assign m_tuser = {res.code, res.kind};
	assign m_tlast = res.last;

endmodule
`default_nettype wire

// File: sv/pmd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_front
// Accepts input bytes, splits off the continuation bit and queues them.
// ----------------------------------------------------------------------------
module pmd_front import pmd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	output logic            q_valid,
	output byte_beat_t      q_beat,
	input  wire logic       q_pop
);

	byte_beat_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign s_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_beat   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{payload: s_tdata[6:0], cont: s_tdata[7], last: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/pmd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_back
// Wire-format parser: varint assembly, tag decode, packed runs, nested
// labels, field skipping and error hold, with a registered result beat.
// ----------------------------------------------------------------------------
module pmd_back import pmd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire byte_beat_t  q_beat,
	output logic             q_pop,
	output logic             out_valid,
	output out_beat_t        out_beat,
	input  wire logic        out_ready
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LENGTH,
		PH_VALUE,
		PH_PACKED,
		PH_SKIP_VARINT,
		PH_SKIP_BYTES
	} phase_t;

	phase_t        ph_q, n_ph;
	logic [63:0]   acc_q, n_acc;
	logic [3:0]    cnt_q, n_cnt;
	logic [28:0]   fld_q, n_fld;
	logic [2:0]    wtype_q, n_wtype;
	logic [31:0]   pk_q, n_pk;
	logic [31:0]   lb_q, n_lb;
	logic          inl_q, n_inl;
	logic [31:0]   sk_q, n_sk;
	logic          err_q, n_err;
	logic          out_valid_q;
	out_beat_t     out_q;

	logic          emit;
	logic [3:0]    kind;
	logic [63:0]   val;
	logic          cls;
	logic [1:0]    err;
	logic          do_reset;
	logic          set_err;
	logic [63:0]   v;
	logic [5:0]    prod;
	logic          known;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_comb begin
		n_ph     = ph_q;
		n_acc    = acc_q;
		n_cnt    = cnt_q;
		n_fld    = fld_q;
		n_wtype  = wtype_q;
		n_pk     = pk_q;
		n_lb     = lb_q;
		n_inl    = inl_q;
		n_sk     = sk_q;
		n_err    = err_q;
		emit     = 1'b0;
		kind     = K_LOCATION;
		val      = '0;
		cls      = 1'b0;
		err      = ERR_NONE;
		do_reset = 1'b0;
		set_err  = 1'b0;
		v        = '0;
		prod     = {2'b00, cnt_q} * 6'd7;
		known    = 1'b0;
		if (err_q) begin
			if (q_beat.last) begin
				do_reset = 1'b1;
				emit     = 1'b1;
				kind     = K_END;
			end
		end else begin
			if (inl_q && lb_q != '0) begin
				n_lb = lb_q - 32'd1;
			end
			if (ph_q == PH_SKIP_BYTES) begin
				if (sk_q != '0) begin
					n_sk = sk_q - 32'd1;
				end
				if (n_sk == '0) begin
					n_ph = PH_TAG;
				end
			end else begin
				if (ph_q == PH_PACKED && pk_q != '0) begin
					n_pk = pk_q - 32'd1;
				end
				if (cnt_q < 4'd10) begin
					n_acc = acc_q | ({57'd0, q_beat.payload} << prod);
					n_cnt = cnt_q + 4'd1;
				end
				if (q_beat.cont) begin
					if (n_cnt >= 4'd10) begin
						err = ERR_OVERLONG;
					end else if (ph_q == PH_PACKED && n_pk == '0) begin
						err = ERR_TRUNC;
					end
				end else begin
					v     = n_acc;
					n_acc = '0;
					n_cnt = '0;
					case (ph_q)
						PH_TAG: begin
							n_fld   = v[31:3];
							n_wtype = v[2:0];
							if (inl_q) begin
								known = (v[31:3] >= 29'd1) && (v[31:3] <= 29'd4);
							end else begin
								known = (v[31:3] == 29'd1) || (v[31:3] == 29'd2);
							end
							case (v[2:0])
								3'd0:    n_ph = known ? PH_VALUE : PH_SKIP_VARINT;
								3'd1: begin
									n_sk = 32'd8;
									n_ph = PH_SKIP_BYTES;
								end
								3'd5: begin
									n_sk = 32'd4;
									n_ph = PH_SKIP_BYTES;
								end
								3'd2:    n_ph = PH_LENGTH;
								default: err = ERR_WIRE;
							endcase
						end
						PH_LENGTH: begin
							if (v[63:32] != '0) begin
								err = ERR_TRUNC;
							end else if (!inl_q && (fld_q == 29'd1 || fld_q == 29'd2)) begin
								n_pk = v[31:0];
								n_ph = (v[31:0] != '0) ? PH_PACKED : PH_TAG;
							end else if (!inl_q && fld_q == 29'd3) begin
								n_ph = PH_TAG;
								if (v[31:0] == '0) begin
									emit = 1'b1;
									kind = K_EMPTY_LABEL;
									cls  = 1'b1;
								end else begin
									n_inl = 1'b1;
									n_lb  = v[31:0];
								end
							end else begin
								n_sk = v[31:0];
								n_ph = (v[31:0] != '0) ? PH_SKIP_BYTES : PH_TAG;
							end
						end
						PH_VALUE: begin
							emit = 1'b1;
							val  = v;
							if (inl_q) begin
								kind = 4'd1 + fld_q[3:0];
							end else begin
								kind = (fld_q == 29'd1) ? K_LOCATION : K_VALUE;
							end
							n_ph = PH_TAG;
						end
						PH_PACKED: begin
							emit = 1'b1;
							val  = v;
							kind = (fld_q == 29'd1) ? K_LOCATION : K_VALUE;
							if (n_pk == '0) begin
								n_ph = PH_TAG;
							end
						end
						default: n_ph = PH_TAG;
					endcase
				end
			end
			if (err == ERR_NONE && n_inl && n_lb == '0) begin
				if (n_ph == PH_TAG && n_cnt == '0) begin
					n_inl = 1'b0;
					cls   = 1'b1;
				end else begin
					err = ERR_TRUNC;
				end
			end
			if (err == ERR_NONE && q_beat.last &&
			    (n_ph != PH_TAG || n_cnt != '0 || n_inl)) begin
				err = ERR_TRUNC;
			end
			if (err != ERR_NONE) begin
				do_reset = 1'b1;
				set_err  = !q_beat.last;
				emit     = 1'b1;
				kind     = K_ERROR;
				val      = '0;
				cls      = 1'b0;
			end else if (q_beat.last) begin
				if (!emit) begin
					kind = K_END;
					val  = '0;
				end
				do_reset = 1'b1;
				emit     = 1'b1;
			end
		end
		if (do_reset) begin
			n_ph    = PH_TAG;
			n_acc   = '0;
			n_cnt   = '0;
			n_fld   = '0;
			n_wtype = '0;
			n_pk    = '0;
			n_lb    = '0;
			n_inl   = 1'b0;
			n_sk    = '0;
			n_err   = set_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_TAG;
			acc_q       <= '0;
			cnt_q       <= '0;
			fld_q       <= '0;
			wtype_q     <= '0;
			pk_q        <= '0;
			lb_q        <= '0;
			inl_q       <= 1'b0;
			sk_q        <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (q_pop) begin
				ph_q        <= n_ph;
				acc_q       <= n_acc;
				cnt_q       <= n_cnt;
				fld_q       <= n_fld;
				wtype_q     <= n_wtype;
				pk_q        <= n_pk;
				lb_q        <= n_lb;
				inl_q       <= n_inl;
				sk_q        <= n_sk;
				err_q       <= n_err;
				out_valid_q <= emit;
				if (emit) begin
					out_q <= '{kind: kind, value: val, closes: cls,
					           last: q_beat.last, code: err};
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: bench/pmd_bench_pkg.sv
// ----------------------------------------------------------------------------
// pmd_bench_pkg
// Wire-format codes and field numbers shared by the decoder bench files.
// ----------------------------------------------------------------------------
package pmd_bench_pkg;

	localparam int TAG_SHIFT        = 3;
	localparam int VARINT_MAX_BYTES = 10;
	localparam int FIXED64_BYTES    = 8;
	localparam int FIXED32_BYTES    = 4;

	localparam logic [2:0] WT_VARINT      = 3'd0;
	localparam logic [2:0] WT_FIXED64     = 3'd1;
	localparam logic [2:0] WT_LEN         = 3'd2;
	localparam logic [2:0] WT_GROUP_START = 3'd3;
	localparam logic [2:0] WT_GROUP_END   = 3'd4;
	localparam logic [2:0] WT_FIXED32     = 3'd5;
	localparam logic [2:0] WT_RSVD6       = 3'd6;
	localparam logic [2:0] WT_RSVD7       = 3'd7;

	// sample message fields
	localparam int F_LOCATION = 1;
	localparam int F_VALUE    = 2;
	localparam int F_LABEL    = 3;

	// label fields
	localparam int F_KEY  = 1;
	localparam int F_STR  = 2;
	localparam int F_NUM  = 3;
	localparam int F_UNIT = 4;

endpackage

// File: bench/pmd_decode_checker.sv
// ----------------------------------------------------------------------------
// pmd_decode_checker
// Watches both stream channels of the sample message decoder, predicts the
// result beat, if any, of every accepted input byte and compares each result beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pmd_decode_checker import pmd_pkg::*, pmd_bench_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,   // [63:0] decoded_value, [64] closes_label
	input  wire logic [5:0]  m_tuser,   // [3:0] kind, [5:4] error_code
	input  wire logic        m_tlast,
	output int               mismatches,
	output int               beats_checked,
	output int               beats_due
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LENGTH,
		PH_VALUE,
		PH_PACKED,
		PH_SKIP_VARINT,
		PH_SKIP_BYTES
	} parse_phase_e;

	parse_phase_e phase;
	logic [63:0]  acc;
	logic [3:0]   vcount;
	logic [28:0]  cur_field;
	logic [2:0]   cur_wtype;
	logic [31:0]  packed_left;
	logic [31:0]  label_left;
	logic         in_label;
	logic [31:0]  skip_left;
	logic         err_hold;

	out_beat_t due_q[$];

	task automatic clear_state();
		phase       = PH_TAG;
		acc         = '0;
		vcount      = '0;
		cur_field   = '0;
		cur_wtype   = '0;
		packed_left = '0;
		label_left  = '0;
		in_label    = 1'b0;
		skip_left   = '0;
		err_hold    = 1'b0;
	endtask

	task automatic report(input string msg);
		if (mismatches < 40)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last, output logic got,
			output out_beat_t r);
		logic              emit;
		logic              closes;
		logic              known;
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] err;
		logic [63:0]       val;
		logic [63:0]       v;
		got    = 1'b0;
		r      = '0;
		emit   = 1'b0;
		closes = 1'b0;
		kind   = K_LOCATION;
		err    = ERR_NONE;
		val    = '0;
		if (err_hold) begin
			if (last) begin
				clear_state();
				got    = 1'b1;
				r.kind = K_END;
				r.last = 1'b1;
			end
			return;
		end
		if (in_label && label_left != 0)
			label_left--;
		if (phase == PH_SKIP_BYTES) begin
			if (skip_left != 0)
				skip_left--;
			if (skip_left == 0)
				phase = PH_TAG;
		end else begin
			if (phase == PH_PACKED && packed_left != 0)
				packed_left--;
			if (vcount < VARINT_MAX_BYTES) begin
				acc = acc | (64'(b[6:0]) << (7 * vcount));
				vcount++;
			end
			if (b[7]) begin
				if (vcount >= VARINT_MAX_BYTES)
					err = ERR_OVERLONG;
				else if (phase == PH_PACKED && packed_left == 0)
					err = ERR_TRUNC;
			end else begin
				v      = acc;
				acc    = '0;
				vcount = '0;
				case (phase)
					PH_TAG: begin
						cur_field = v[TAG_SHIFT +: 29];
						cur_wtype = v[2:0];
						case (cur_wtype)
							WT_VARINT: begin
								known = in_label ? (cur_field >= F_KEY && cur_field <= F_UNIT)
									: (cur_field == F_LOCATION || cur_field == F_VALUE);
								phase = known ? PH_VALUE : PH_SKIP_VARINT;
							end
							WT_FIXED64: begin
								skip_left = FIXED64_BYTES;
								phase     = PH_SKIP_BYTES;
							end
							WT_FIXED32: begin
								skip_left = FIXED32_BYTES;
								phase     = PH_SKIP_BYTES;
							end
							WT_LEN: phase = PH_LENGTH;
							default: err = ERR_WIRE;
						endcase
					end
					PH_LENGTH: begin
						if (v[63:32] != 0) begin
							err = ERR_TRUNC;
						end else if (!in_label && (cur_field == F_LOCATION
								|| cur_field == F_VALUE)) begin
							packed_left = v[31:0];
							phase       = (v == 0) ? PH_TAG : PH_PACKED;
						end else if (!in_label && cur_field == F_LABEL) begin
							phase = PH_TAG;
							if (v == 0) begin
								emit   = 1'b1;
								kind   = K_EMPTY_LABEL;
								closes = 1'b1;
							end else begin
								in_label   = 1'b1;
								label_left = v[31:0];
							end
						end else begin
							skip_left = v[31:0];
							phase     = (v == 0) ? PH_TAG : PH_SKIP_BYTES;
						end
					end
					PH_VALUE: begin
						emit = 1'b1;
						val  = v;
						if (in_label)
							kind = K_VALUE + KIND_W'(cur_field);
						else
							kind = (cur_field == F_LOCATION) ? K_LOCATION : K_VALUE;
						phase = PH_TAG;
					end
					PH_PACKED: begin
						emit = 1'b1;
						val  = v;
						kind = (cur_field == F_LOCATION) ? K_LOCATION : K_VALUE;
						if (packed_left == 0)
							phase = PH_TAG;
					end
					default: phase = PH_TAG;
				endcase
			end
		end
		// label boundary must fall between fields
		if (err == ERR_NONE && in_label && label_left == 0) begin
			if (phase == PH_TAG && vcount == 0) begin
				in_label = 1'b0;
				closes   = 1'b1;
			end else begin
				err = ERR_TRUNC;
			end
		end
		if (err == ERR_NONE && last && (phase != PH_TAG || vcount != 0 || in_label))
			err = ERR_TRUNC;
		if (err != ERR_NONE) begin
			clear_state();
			if (!last)
				err_hold = 1'b1;
			got    = 1'b1;
			r.kind = K_ERROR;
			r.last = last;
			r.code = err;
			return;
		end
		if (last) begin
			if (!emit) begin
				kind = K_END;
				val  = '0;
			end
			clear_state();
		end
		if (last || emit) begin
			got      = 1'b1;
			r.kind   = kind;
			r.value  = val;
			r.closes = closes;
			r.last   = last;
		end
	endtask

	initial begin
		clear_state();
		mismatches    = 0;
		beats_checked = 0;
		beats_due     = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		logic      got;
		out_beat_t pred;
		out_beat_t seen;
		out_beat_t want;
		if (!arst_n) begin
			clear_state();
			due_q.delete();
			beats_due <= 0;
		end else begin
			// results first: a byte accepted at this edge cannot have its beat out yet
			if (m_tvalid && m_tready) begin
				seen.kind   = m_tuser[3:0];
				seen.code   = m_tuser[5:4];
				seen.value  = m_tdata[63:0];
				seen.closes = m_tdata[64];
				seen.last   = m_tlast;
				if (due_q.size() == 0) begin
					report($sformatf("unexpected beat kind %0d value %h code %0d",
						seen.kind, seen.value, seen.code));
				end else begin
					want = due_q.pop_front();
					if (seen.kind !== want.kind || seen.value !== want.value
							|| seen.closes !== want.closes || seen.last !== want.last
							|| seen.code !== want.code)
						report($sformatf({"beat %0d got kind %0d value %h closes %b last %b",
							" code %0d, want kind %0d value %h closes %b last %b code %0d"},
							beats_checked, seen.kind, seen.value, seen.closes, seen.last,
							seen.code, want.kind, want.value, want.closes, want.last,
							want.code));
					beats_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast, got, pred);
				if (got)
					due_q.insert(due_q.size(), pred);
			end
			beats_due <= due_q.size();
		end
	end

endmodule

// File: bench/protobuf_sample_message_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// protobuf_sample_message_decoder_core_tb
// Feeds encoded sample messages byte by byte into the decoder: a few
// hand-built messages for every result kind and error, then random
// well-formed and malformed messages, with random gaps on both channels.
// ----------------------------------------------------------------------------
module protobuf_sample_message_decoder_core_tb import pmd_bench_pkg::*;;

	localparam int ITEM_TARGET = 750;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	int mismatches;
	int beats_checked;
	int beats_due;
	int cycles      = 0;
	int bytes_sent  = 0;
	int msgs_sent   = 0;
	int broken_msgs = 0;
	bit steady      = 1'b0;

	logic [7:0] body[$];

	protobuf_sample_message_decoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pmd_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.beats_checked (beats_checked),
		.beats_due     (beats_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d result beats outstanding", beats_due);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int unsigned nbits;
		v     = {$urandom, $urandom};
		nbits = $urandom_range(64);
		if (nbits < 64)
			v = v & ((64'd1 << nbits) - 64'd1);
		return v;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		body.insert(body.size(), b);
	endtask

	task automatic put_varint(input logic [63:0] v);
		do begin
			add_byte({(v >> 7) != 0, v[6:0]});
			v = v >> 7;
		end while (v != 0);
	endtask

	task automatic put_tag(input logic [63:0] fnum, input logic [2:0] wt);
		put_varint((fnum << TAG_SHIFT) | 64'(wt));
	endtask

	// insert the length of everything from start onward in front of it
	task automatic wrap_len(input int start);
		int         mark;
		logic [7:0] b;
		mark = body.size();
		put_varint(64'(mark - start));
		repeat (body.size() - mark) begin
			b = body.pop_back();
			body.insert(start, b);
		end
	endtask

	task automatic put_unknown(input bit nested);
		logic [2:0]  wt;
		logic [63:0] fnum;
		int          start;
		case ($urandom_range(3))
			0: wt = WT_VARINT;
			1: wt = WT_FIXED64;
			2: wt = WT_FIXED32;
			default: wt = WT_LEN;
		endcase
		case ($urandom_range(3))
			0: fnum = 0;
			1: fnum = 64'($urandom_range(40));
			2: fnum = 64'($urandom_range(29'h1FFF_FFFF, 5));
			// bits above the tag's 32nd are ignored
			default: fnum = 64'($urandom_range(40)) | (64'($urandom) << 29);
		endcase
		if (wt == WT_VARINT && fnum[28:0] != 0
				&& fnum[28:0] <= (nested ? F_UNIT : F_VALUE))
			fnum = fnum + 8;
		if (wt == WT_LEN && !nested && fnum[28:0] != 0 && fnum[28:0] <= F_LABEL)
			fnum = fnum + 8;
		put_tag(fnum, wt);
		case (wt)
			WT_VARINT: put_varint(rand_value());
			WT_FIXED64: repeat (FIXED64_BYTES) add_byte(8'($urandom));
			WT_FIXED32: repeat (FIXED32_BYTES) add_byte(8'($urandom));
			default: begin
				start = body.size();
				repeat ($urandom_range(6)) add_byte(8'($urandom));
				wrap_len(start);
			end
		endcase
	endtask

	task automatic put_label();
		int start;
		put_tag(F_LABEL, WT_LEN);
		start = body.size();
		repeat ($urandom_range(4)) begin
			if ($urandom_range(3) != 0) begin
				put_tag(64'($urandom_range(F_UNIT, F_KEY)), WT_VARINT);
				put_varint(rand_value());
			end else begin
				put_unknown(1'b1);
			end
		end
		wrap_len(start);
	endtask

	task automatic put_fields(input int n);
		int start;
		repeat (n) begin
			case ($urandom_range(5))
				0, 1: begin
					put_tag(64'($urandom_range(F_VALUE, F_LOCATION)), WT_VARINT);
					put_varint(rand_value());
				end
				2: begin
					put_tag(64'($urandom_range(F_VALUE, F_LOCATION)), WT_LEN);
					start = body.size();
					repeat ($urandom_range(4)) put_varint(rand_value());
					wrap_len(start);
				end
				3, 4: put_label();
				default: put_unknown(1'b0);
			endcase
		end
	endtask

	task automatic put_broken();
		int cut;
		int n;
		case ($urandom_range(7))
			0: begin
				put_fields($urandom_range(4, 1));
				if (body.size() > 1) begin
					cut = $urandom_range(body.size() - 1, 1);
					while (body.size() > cut)
						void'(body.pop_back());
				end
			end
			1: begin
				put_fields($urandom_range(4, 1));
				body[$urandom_range(body.size() - 1)] = 8'($urandom);
			end
			2: begin
				put_fields($urandom_range(2));
				case ($urandom_range(3))
					0: put_tag(64'($urandom_range(40)), WT_GROUP_START);
					1: put_tag(64'($urandom_range(40)), WT_GROUP_END);
					2: put_tag(64'($urandom_range(40)), WT_RSVD6);
					default: put_tag(64'($urandom_range(40)), WT_RSVD7);
				endcase
				put_fields($urandom_range(2));
			end
			3: begin
				put_tag(F_VALUE, WT_VARINT);
				repeat ($urandom_range(12, 10)) add_byte(8'h80 | 8'($urandom));
				add_byte(8'($urandom_range(127)));
				put_fields($urandom_range(2));
			end
			4: begin
				put_tag(64'($urandom_range(40, 1)), WT_LEN);
				put_varint(64'h1_0000_0000 | rand_value());
				put_fields($urandom_range(2));
			end
			5: begin
				put_tag(64'($urandom_range(F_VALUE, F_LOCATION)), WT_LEN);
				n = $urandom_range(3, 1);
				put_varint(64'(n));
				repeat (n) add_byte(8'h80 | 8'($urandom));
				add_byte(8'h01);
				put_fields($urandom_range(2));
			end
			6: begin
				put_tag(F_LABEL, WT_LEN);
				put_varint(64'($urandom_range(2, 1)));
				put_tag(F_NUM, WT_VARINT);
				put_varint(rand_value() | 64'h4000);
				put_fields($urandom_range(2));
			end
			default: repeat ($urandom_range(20, 1)) add_byte(8'($urandom));
		endcase
		if (body.size() == 0)
			add_byte(8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!steady && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_body();
		foreach (body[i])
			send_byte(body[i], i == body.size() - 1);
		body.delete();
		msgs_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (beats_due != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest location id and largest value
		put_tag(F_LOCATION, WT_VARINT);
		put_varint(0);
		put_tag(F_VALUE, WT_VARINT);
		put_varint('1);
		send_body();

		// packed ids, full label closing on a skipped field, empty label last
		put_tag(F_LOCATION, WT_LEN);
		start = body.size();
		put_varint(1);
		put_varint(300);
		wrap_len(start);
		put_tag(F_LABEL, WT_LEN);
		start = body.size();
		put_tag(F_KEY, WT_VARINT);
		put_varint(1);
		put_tag(F_STR, WT_VARINT);
		put_varint(2);
		put_tag(F_NUM, WT_VARINT);
		put_varint(3);
		put_tag(F_UNIT, WT_VARINT);
		put_varint(4);
		put_tag(9, WT_VARINT);
		put_varint(5);
		wrap_len(start);
		put_tag(F_LABEL, WT_LEN);
		put_varint(0);
		send_body();

		// skipped fields only, zero-length packed run, field zero
		put_tag(5, WT_FIXED64);
		repeat (FIXED64_BYTES) add_byte(8'hFF);
		put_tag(6, WT_FIXED32);
		repeat (FIXED32_BYTES) add_byte(8'h00);
		put_tag(7, WT_LEN);
		start = body.size();
		add_byte(8'h80);
		add_byte(8'hFF);
		wrap_len(start);
		put_tag(F_VALUE, WT_LEN);
		put_varint(0);
		put_tag(0, WT_VARINT);
		put_varint(127);
		send_body();

		// overlong varint, then held bytes until the end
		put_tag(F_VALUE, WT_VARINT);
		repeat (11) add_byte(8'hFF);
		add_byte(8'h01);
		send_body();

		// group wire type
		put_tag(4, WT_GROUP_START);
		add_byte(8'h00);
		send_body();

		// length beyond 32 bits
		put_tag(9, WT_LEN);
		put_varint(64'h2_0000_0000);
		send_body();

		// packed run ends inside a varint
		put_tag(F_LOCATION, WT_LEN);
		put_varint(1);
		add_byte(8'h80);
		add_byte(8'h01);
		send_body();

		// label runs out inside a field
		put_tag(F_LABEL, WT_LEN);
		put_varint(1);
		put_tag(F_KEY, WT_VARINT);
		put_varint(5);
		send_body();

		// message cut after a tag, error on the final byte
		put_tag(F_LOCATION, WT_VARINT);
		send_body();

		wait_drained();

		while (bytes_sent < ITEM_TARGET) begin
			steady = (bytes_sent >= 300 && bytes_sent < 450);
			if ($urandom_range(99) < 5)
				wait_drained();
			if ($urandom_range(9) < 7) begin
				put_fields($urandom_range(6, 1));
			end else begin
				put_broken();
				broken_msgs++;
			end
			send_body();
		end
		steady = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);

		$display("%0d bytes in %0d messages (%0d malformed), %0d result beats checked",
			bytes_sent, msgs_sent, broken_msgs, beats_checked);
		if (beats_due != 0)
			$display("%0d expected result beats never arrived", beats_due);
		if (mismatches == 0 && beats_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
